>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Property whose consequent must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/gnbfp_pkg.sv
// Package of the GPS frame parser: byte codes, parse state codes, event codes, types.
package gnbfp_pkg;

  localparam logic [7:0] SYM_DOLLAR = 8'h24;
  localparam logic [7:0] SYM_SYNC0  = 8'hA0;
  localparam logic [7:0] SYM_SYNC1  = 8'hA1;
  localparam logic [7:0] SYM_CR     = 8'h0D;
  localparam logic [7:0] SYM_LF     = 8'h0A;

  localparam logic [3:0] ST_WAIT    = 4'd0;
  localparam logic [3:0] ST_LINE    = 4'd1;
  localparam logic [3:0] ST_LINE_CR = 4'd2;
  localparam logic [3:0] ST_SYNC    = 4'd3;
  localparam logic [3:0] ST_LEN_HI  = 4'd4;
  localparam logic [3:0] ST_LEN_LO  = 4'd5;
  localparam logic [3:0] ST_PAYLOAD = 4'd6;
  localparam logic [3:0] ST_CHECK   = 4'd7;
  localparam logic [3:0] ST_END_CR  = 4'd8;
  localparam logic [3:0] ST_END_LF  = 4'd9;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_LINE_CHAR = 3'd1;
  localparam logic [2:0] EV_PAYLOAD   = 3'd2;
  localparam logic [2:0] EV_LINE_DONE = 3'd3;
  localparam logic [2:0] EV_BIN_GOOD  = 3'd4;
  localparam logic [2:0] EV_ERROR     = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } step_t;

endpackage

>>> rtl/gps_nmea_binary_frame_parser.sv
// Top level of the GPS frame parser: input register, parse core, result register.
// A byte accepted into the input register gives its event at out_valid once the parse step takes it.
// Throughput: one byte per cycle while out_stall does not hold a waiting result beat.
// Results: exactly one event beat per byte, including event 0 for silently absorbed bytes.
// Reset: synchronous, active high; empties both registers and returns parsing to
// waiting for a start byte with all counters, the length and the XOR cleared.
module gps_nmea_binary_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res
);
  import gnbfp_pkg::*;

  `include "assert_macros.svh"

  // Input register: holds one byte until the parse step takes it.
  logic       s1_vld;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       in_take;
  logic [2:0] core_event;
  step_t      step;

  // Advance the held byte when the result register is empty or being drained.
  assign s1_adv   = s1_vld & (~out_valid | ~out_stall);
  // Stall upstream only when the input register is full and cannot move on.
  assign in_stall = s1_vld & ~s1_adv;
  assign in_take  = in_valid & ~in_stall;

  assign step.valid = s1_adv;
  assign step.data  = s1_byte;

  gnbfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .event_res (core_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_take) begin
      s1_vld <= 1'b1;
    end else if (s1_adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  // Result register: load on every parse step, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      event_res <= core_event;
    end
  end

  // Upstream is held back only while a result beat is waiting downstream.
  `ASSERT_ALWAYS(a_stall_cause, !in_stall || (s1_vld && out_valid && out_stall))
  // Every parse step leaves a result beat behind.
  `ASSERT_NEXT(a_step_result, s1_adv, out_valid)
  // Only defined event codes reach the output.
  `ASSERT_ALWAYS(a_event_range, !out_valid || (event_res <= EV_ERROR))

endmodule

>>> rtl/gnbfp_core.sv
// Parse state machine of the GPS frame parser: state registers and event decode.
module gnbfp_core (
  input  logic              clk,
  input  logic              rst,
  input  gnbfp_pkg::step_t  step,
  output logic [2:0]        event_res
);
  import gnbfp_pkg::*;

  logic [3:0]  parse_state;
  logic [3:0]  parse_state_next;
  logic [15:0] payload_count;
  logic [15:0] payload_count_next;
  logic [15:0] declared_length;
  logic [15:0] declared_length_next;
  logic [7:0]  running_xor;
  logic [7:0]  running_xor_next;
  logic [31:0] noise_total;
  logic [31:0] noise_total_next;
  logic [15:0] count_inc;
  logic [7:0]  xor_new;

  assign count_inc = payload_count + 16'd1;
  assign xor_new   = running_xor ^ step.data;

  always_comb begin
    parse_state_next     = parse_state;
    payload_count_next   = payload_count;
    declared_length_next = declared_length;
    running_xor_next     = running_xor;
    noise_total_next     = noise_total;
    event_res            = EV_NONE;
    case (parse_state)
      ST_WAIT: begin
        payload_count_next = '0;
        if (step.data == SYM_DOLLAR) begin
          parse_state_next = ST_LINE;
        end else if (step.data == SYM_SYNC0) begin
          parse_state_next = ST_SYNC;
        end else begin
          noise_total_next = noise_total + 32'd1;
        end
      end
      ST_LINE: begin
        if (step.data == SYM_CR) begin
          parse_state_next = ST_LINE_CR;
        end else begin
          event_res = EV_LINE_CHAR;
        end
      end
      ST_LINE_CR: begin
        parse_state_next = ST_WAIT;
        event_res = (step.data == SYM_LF) ? EV_LINE_DONE : EV_ERROR;
      end
      ST_SYNC: begin
        if (step.data == SYM_SYNC1) begin
          parse_state_next = ST_LEN_HI;
        end else begin
          // second byte is swallowed, not rescanned as a start byte
          parse_state_next = ST_WAIT;
          noise_total_next = noise_total + 32'd2;
        end
      end
      ST_LEN_HI: begin
        declared_length_next = {step.data, 8'h00};
        parse_state_next     = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        declared_length_next = {declared_length[15:8], step.data};
        running_xor_next     = '0;
        parse_state_next     = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        payload_count_next = count_inc;
        running_xor_next   = xor_new;
        event_res          = EV_PAYLOAD;
        // a zero length still takes one payload byte
        if (count_inc >= declared_length) begin
          parse_state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        running_xor_next = xor_new;
        if (xor_new == 8'h00) begin
          parse_state_next = ST_END_CR;
        end else begin
          parse_state_next = ST_WAIT;
          event_res        = EV_ERROR;
        end
      end
      ST_END_CR: begin
        if (step.data == SYM_CR) begin
          parse_state_next = ST_END_LF;
        end else begin
          parse_state_next = ST_WAIT;
          event_res        = EV_ERROR;
        end
      end
      ST_END_LF: begin
        parse_state_next = ST_WAIT;
        event_res = (step.data == SYM_LF) ? EV_BIN_GOOD : EV_ERROR;
      end
      default: begin
        parse_state_next = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state     <= ST_WAIT;
      payload_count   <= '0;
      declared_length <= '0;
      running_xor     <= '0;
      noise_total     <= '0;
    end else if (step.valid) begin
      parse_state     <= parse_state_next;
      payload_count   <= payload_count_next;
      declared_length <= declared_length_next;
      running_xor     <= running_xor_next;
      noise_total     <= noise_total_next;
    end
  end

endmodule
